// File: hdl/sss_pkg.sv
// Shared types and constants for the stable score sorter.
// Used by sss_cell, stable_score_sorter, sss_order_checker and the testbench top; depends on nothing else.
package sss_pkg;

    localparam int MAX_ROWS_DEF = 16;
    localparam int SCORE_W      = 32;
    localparam int TAG_W        = 8;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic        [TAG_W-1:0]   row_tag;
        logic                      last_in;
    } sss_req_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0] sorted_score;
        logic        [TAG_W-1:0]   sorted_tag;
        logic                      last_out;
        logic                      overflow;
    } sss_result_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic        [TAG_W-1:0]   tag;
    } sss_record_t;

    // Control broadcast to every cell of the row.
    typedef struct packed {
        logic insert;
        logic drain;
    } sss_ctrl_t;

    // What a cell shows its neighbors.
    typedef struct packed {
        logic        valid;
        logic        shift;
        sss_record_t rec;
    } sss_link_t;

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } sss_state_t;

endpackage

// File: hdl/sss_cell.sv
// One cell of the sorting row: holds one record and its valid bit.
// Depends on sss_pkg for the record, link and control types.
module sss_cell
    import sss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sss_ctrl_t   ctrl,
    input  sss_record_t new_rec,
    input  sss_link_t   left_link,
    input  sss_link_t   right_link,
    output sss_link_t   cell_link
);

    logic        valid_reg;
    logic        valid_next;
    sss_record_t rec_reg;
    sss_record_t rec_next;
    logic        shift;

    // Strictly greater stored scores move up, so equal scores keep arrival order.
    assign shift = valid_reg && ($signed(new_rec.score) < $signed(rec_reg.score));

    always_comb
    begin
        valid_next = valid_reg;
        rec_next   = rec_reg;
        if (ctrl.drain)
        begin
            valid_next = right_link.valid;
            rec_next   = right_link.rec;
        end
        else if (ctrl.insert && (shift || (!valid_reg && left_link.valid)))
        begin
            valid_next = 1'b1;
            rec_next   = left_link.shift ? left_link.rec : new_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign cell_link.valid = valid_reg;
    assign cell_link.shift = shift;
    assign cell_link.rec   = rec_reg;

endmodule

// File: hdl/stable_score_sorter.sv
// Top level of the stable score sorter: control and a row of sss_cell instances.
// Depends on sss_pkg and sss_cell.
//
// Records are accepted one per cycle (start high, busy low) and are placed at
// once into a sorted row of MAX_ROWS cells. The record with last_in set closes
// the set; from the next cycle the row shifts toward cell 0 and gives one
// result per cycle, N results for N held records, marked by result_valid, with
// last_out on the final one. Busy is high while those results are given. The
// receiver cannot stall: every result is on the ports for one cycle only.
// Records arriving while the row is full are dropped and overflow is set on
// every result of that set.
module stable_score_sorter
    import sss_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  sss_req_t    req,
    output logic        result_valid,
    output sss_result_t result
);

    sss_state_t state_reg;
    sss_state_t state_next;
    logic       overflow_reg;
    logic       overflow_next;

    sss_ctrl_t     ctrl;
    sss_record_t   new_rec;
    sss_link_t     link [MAX_ROWS];
    logic [MAX_ROWS-1:0] valid_vec;
    logic          full;
    logic          accept;
    logic          final_out;

    assign new_rec.score = req.score;
    assign new_rec.tag   = req.row_tag;

    assign full      = link[MAX_ROWS-1].valid;
    assign accept    = start && !busy;
    assign final_out = !link[1].valid;

    assign ctrl.insert = (state_reg == ST_LOAD) && accept && !full;
    assign ctrl.drain  = (state_reg == ST_DRAIN);

    for (genvar i = 0; i < MAX_ROWS; i++)
    begin : g_cell
        sss_link_t left_in;
        sss_link_t right_in;

        if (i == 0)
        begin : g_head
            assign left_in = '{valid: 1'b1, shift: 1'b0, rec: '0};
        end
        else
        begin : g_body
            assign left_in = link[i-1];
        end

        if (i == MAX_ROWS - 1)
        begin : g_tail
            assign right_in = '{valid: 1'b0, shift: 1'b0, rec: '0};
        end
        else
        begin : g_next
            assign right_in = link[i+1];
        end

        sss_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .new_rec    (new_rec),
            .left_link  (left_in),
            .right_link (right_in),
            .cell_link  (link[i])
        );

        assign valid_vec[i] = link[i].valid;
    end

    always_comb
    begin
        state_next    = state_reg;
        overflow_next = overflow_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (full)
                    begin
                        overflow_next = 1'b1;
                    end
                    if (req.last_in)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (final_out)
                begin
                    state_next    = ST_LOAD;
                    overflow_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            overflow_reg <= overflow_next;
        end
    end

    assign busy                = (state_reg == ST_DRAIN);
    assign result_valid        = (state_reg == ST_DRAIN);
    assign result.sorted_score = link[0].rec.score;
    assign result.sorted_tag   = link[0].rec.tag;
    assign result.last_out     = final_out;
    assign result.overflow     = overflow_reg;

    // A result always comes from a held record.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> link[0].valid)
        else $error("result given from an empty head cell");

    // Held records always form one contiguous run from cell 0.
    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + 1'b1)) == '0)
        else $error("gap in the row of held records");

    // An accepted record with room grows the row by exactly one.
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.insert |=> $countones(valid_vec) == $past($countones(valid_vec)) + 1)
        else $error("insert did not add exactly one record");

    // After the final result the row is empty and ready for a new set.
    a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last_out) |=> (!busy && valid_vec == '0 && !overflow_reg))
        else $error("row not cleared after the final result");

endmodule

// File: tb/sss_order_checker.sv
`timescale 1ns / 1ps
// Checker for the stable score sorter: keeps its own sorted row of held records,
// predicts every result from the accepted requests and compares field by field.
// Depends on sss_pkg.
module sss_order_checker
    import sss_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  sss_req_t    req,
    input  logic        result_valid,
    input  sss_result_t result,
    output int          errors,
    output int          pending
);

    logic signed [SCORE_W-1:0] held_scores [MAX_ROWS];
    logic        [TAG_W-1:0]   held_tags   [MAX_ROWS];
    int                        held_count;
    logic                      dropped_seen;
    sss_result_t               sorted_due [$];

    task automatic absorb_request(input sss_req_t r);
        int          pos;
        sss_result_t res;
        if (held_count < MAX_ROWS)
        begin
            pos = held_count;
            // Only strictly larger scores move up, so equal scores keep arrival order.
            while (pos > 0 && held_scores[pos-1] > $signed(r.score))
            begin
                held_scores[pos] = held_scores[pos-1];
                held_tags[pos]   = held_tags[pos-1];
                pos--;
            end
            held_scores[pos] = $signed(r.score);
            held_tags[pos]   = r.row_tag;
            held_count++;
        end
        else
        begin
            dropped_seen = 1'b1;
        end
        if (r.last_in)
        begin
            for (int k = 0; k < held_count; k++)
            begin
                res.sorted_score = held_scores[k];
                res.sorted_tag   = held_tags[k];
                res.last_out     = (k + 1 == held_count);
                res.overflow     = dropped_seen;
                sorted_due.push_back(res);
            end
            held_count   = 0;
            dropped_seen = 1'b0;
        end
    endtask

    task automatic check_result(input sss_result_t got);
        sss_result_t want;
        if (sorted_due.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result: expected none, actual %0d %0d %0b %0b",
                     $time, $signed(got.sorted_score), got.sorted_tag, got.last_out,
                     got.overflow);
        end
        else
        begin
            want = sorted_due.pop_front();
            if (got !== want)
            begin
                errors++;
                $display("%0t: result mismatch: expected %0d %0d %0b %0b, actual %0d %0d %0b %0b",
                         $time, $signed(want.sorted_score), want.sorted_tag,
                         want.last_out, want.overflow, $signed(got.sorted_score),
                         got.sorted_tag, got.last_out, got.overflow);
            end
        end
    endtask

    initial
    begin
        errors       = 0;
        pending      = 0;
        held_count   = 0;
        dropped_seen = 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count   = 0;
            dropped_seen = 1'b0;
            sorted_due.delete();
            pending      = 0;
        end
        else
        begin
            if (result_valid)
                check_result(result);
            if (start && !busy)
                absorb_request(req);
            pending = sorted_due.size();
        end
    end

endmodule

// File: tb/stable_score_sorter_tb.sv
`timescale 1ns / 1ps
// Testbench top for the stable score sorter: clock, reset and request stimulus.
// Depends on sss_pkg, stable_score_sorter and sss_order_checker.
module stable_score_sorter_tb;
    import sss_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 4 * MAX_ROWS_DEF;

    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    sss_req_t    req;
    logic        result_valid;
    sss_result_t result;
    int          errors;
    int          pending;
    int          idle_pct;
    int          cycle_count;

    stable_score_sorter #(
        .MAX_ROWS(MAX_ROWS_DEF)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .result_valid(result_valid),
        .result      (result)
    );

    sss_order_checker #(
        .MAX_ROWS(MAX_ROWS_DEF)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .result_valid(result_valid),
        .result      (result),
        .errors      (errors),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_record(input logic signed [SCORE_W-1:0] sc,
                               input logic [TAG_W-1:0] tag, input logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start       = 1'b1;
        req.score   = sc;
        req.row_tag = tag;
        req.last_in = last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic signed [SCORE_W-1:0] pick_score(input int mode);
        logic signed [SCORE_W-1:0] sc;
        case (mode)
            0: sc = $urandom();
            1: sc = $signed($urandom_range(6)) - 3;
            2:
            begin
                case ($urandom_range(3))
                    0: sc = SCORE_MIN;
                    1: sc = SCORE_MAX;
                    2: sc = '0;
                    default: sc = '1;
                endcase
            end
            default: sc = $urandom_range(1) ? $urandom() : $urandom_range(3);
        endcase
        return sc;
    endfunction

    task automatic send_random_sets(input int n_items);
        int sent;
        int set_len;
        int mode;
        int pick;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            // Some sets run past the row capacity, many are short, the rest anywhere.
            if (pick < 12)
                set_len = $urandom_range(MAX_ROWS_DEF + 5, MAX_ROWS_DEF + 1);
            else if (pick < 30)
                set_len = $urandom_range(3, 1);
            else
                set_len = $urandom_range(MAX_ROWS_DEF, 1);
            mode = $urandom_range(3);
            for (int k = 0; k < set_len; k++)
                send_record(pick_score(mode), TAG_W'($urandom()), k + 1 == set_len);
            sent += set_len;
        end
    endtask

    initial
    begin
        cycle_count = 0;
        idle_pct    = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        req         = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Single record holding the largest score.
        send_record(SCORE_MAX, 8'hFF, 1'b1);

        // Extremes and a run of equal scores that must keep arrival order.
        send_record(SCORE_MAX, 8'd1, 1'b0);
        send_record(32'sd5, 8'd2, 1'b0);
        send_record(SCORE_MIN, 8'd0, 1'b0);
        send_record(32'sd5, 8'd3, 1'b0);
        send_record(-32'sd1, 8'd4, 1'b0);
        send_record(32'sd5, 8'd5, 1'b0);
        send_record(32'sd0, 8'hFF, 1'b1);

        // Full row, then a closing record that no longer fits and is dropped.
        for (int k = 0; k < MAX_ROWS_DEF; k++)
            send_record(SCORE_MAX - k, k[TAG_W-1:0], 1'b0);
        send_record(SCORE_MIN, 8'hAA, 1'b1);

        idle_pct = 9;
        send_random_sets(160);
        idle_pct = 51;
        send_random_sets(160);
        idle_pct = 0;
        send_random_sets(160);

        start = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
